### hdl/odle_pkg.sv
// ----------------------------------------------------------------------------
// odle_pkg
// Shared widths, codes and state types of the ordered deque list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package odle_pkg;

   // default store depth
   localparam int CAPACITY_DEF = 64;

   // fixed field widths
   localparam int KEY_W    = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   // command actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR         = 3'd0,
      ACT_PUSH_FRONT    = 3'd1,
      ACT_PUSH_BACK     = 3'd2,
      ACT_POP_FRONT     = 3'd3,
      ACT_POP_BACK      = 3'd4,
      ACT_SORTED_INSERT = 3'd5,
      ACT_DELETE_KEY    = 3'd6,
      ACT_REVERSE       = 3'd7
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_POP,
      ST_SHIFT,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // list update applied when a command finishes
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INSERT,
      OP_REMOVE,
      OP_CLEAR,
      OP_FLIP
   } op_type;

endpackage

`default_nettype wire

### hdl/ordered_deque_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_deque_list_engine
// Ordered deque of signed keys in a circular single-port-read memory, with
// push/pop at both ends, sorted insert, delete by key and reverse.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its one result shows
// on the rsp_ ports for exactly one cycle, flagged by rsp_valid, as busy drops.
// The receiver cannot stall. Clear, pushes and reverse go from accept straight
// to the finish state; pops on a non-empty list first pass a pop state that
// reads the end entry. Sorted insert and delete by key read one entry per
// cycle to find their position, then move the entries past it one per cycle,
// and a drain state writes the last moved entry. On a list in forward order
// the scan and the move together cover the list about once; in reversed order
// both cover the same end of it. The single memory read port, one access a
// cycle, sets this pace. No clearing pass runs after reset.
`default_nettype none

module ordered_deque_list_engine
   import odle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ACTION_W-1:0]        req_action,
   input  wire logic signed [KEY_W-1:0]    req_key,
   output logic                            busy,
   output logic                            rsp_valid,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic signed [KEY_W-1:0]         rsp_removed_key,
   output logic [CNT_W-1:0]                rsp_entry_count
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // physical slot of a position counted from the front slot
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   // control and list state
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   status_type         stat_ff, stat_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   front_ff, front_in;
   logic               rev_ff, rev_in;

   // command payload and progress
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [KEY_W-1:0]   removed_ff, removed_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]   sh_rd_ff, sh_rd_in;
   logic [CNT_W-1:0]   wr_phys_ff, wr_phys_in;
   logic               wr_vld_ff, wr_vld_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [KEY_W-1:0]   rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // key memory
   logic [KEY_W-1:0]   key_mem [CAPACITY];
   logic [KEY_W-1:0]   rd_data_ff;
   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [KEY_W-1:0]   wr_data;

   // decode helpers
   logic               accept;
   action_type         act;
   logic               full;
   logic               empty;
   logic [CNT_W-1:0]   cnt_last;
   logic [IDX_W-1:0]   front_dec;
   logic [IDX_W-1:0]   front_inc;
   logic [CNT_W-1:0]   push_pos;
   logic [CNT_W-1:0]   pop_pos;
   logic               scan_match;
   logic               scan_hit;
   logic               scan_end;
   logic [CNT_W-1:0]   scan_i;
   logic [CNT_W-1:0]   launch_pos;
   logic               shift_need;
   logic [CNT_W-1:0]   sh_stop;

   assign accept    = start && (state_ff == ST_IDLE);
   assign act       = action_type'(req_action);
   assign full      = (cnt_ff == CNT_W'(CAPACITY));
   assign empty     = (cnt_ff == '0);
   assign cnt_last  = cnt_ff - CNT_W'(1);
   assign front_dec = (front_ff == '0) ? IDX_W'(CAPACITY - 1) : front_ff - IDX_W'(1);
   assign front_inc = (front_ff == IDX_W'(CAPACITY - 1)) ? '0 : front_ff + IDX_W'(1);

   // end positions in physical order, taking the orientation into account
   assign push_pos = ((act == ACT_PUSH_FRONT) != rev_ff) ? '0 : cnt_ff;
   assign pop_pos  = ((act == ACT_POP_FRONT) != rev_ff) ? '0 : cnt_last;

   // compare the entry read back during a scan
   assign scan_match = (op_ff == OP_INSERT) ? ($signed(rd_data_ff) > $signed(key_ff))
                                            : (rd_data_ff == key_ff);
   assign scan_hit   = rd_vld_ff && scan_match;
   assign scan_end   = rd_vld_ff && (rd_idx_ff == cnt_last);
   assign scan_i     = scan_hit ? rd_idx_ff : cnt_ff;

   // physical position the insert or removal works on
   always_comb begin
      launch_pos = pos_ff;
      if (state_ff == ST_SCAN) begin
         if (op_ff == OP_INSERT) begin
            launch_pos = rev_ff ? (cnt_ff - scan_i) : scan_i;
         end else begin
            launch_pos = rev_ff ? (cnt_last - scan_i) : scan_i;
         end
      end
   end

   // entries need moving unless the position is at either end
   assign shift_need = (op_ff == OP_INSERT)
                     ? ((launch_pos != '0) && (launch_pos != cnt_ff))
                     : ((launch_pos != '0) && (launch_pos != cnt_last));
   assign sh_stop    = (op_ff == OP_INSERT) ? pos_ff : cnt_last;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_POP_FRONT, ACT_POP_BACK: state_in = empty ? ST_FINISH : ST_POP;
                  ACT_SORTED_INSERT:           state_in = (full || empty) ? ST_FINISH : ST_SCAN;
                  ACT_DELETE_KEY:              state_in = empty ? ST_FINISH : ST_SCAN;
                  default:                     state_in = ST_FINISH;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_end) begin
               if ((op_ff == OP_REMOVE) && !scan_hit) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = shift_need ? ST_SHIFT : ST_FINISH;
               end
            end
         end
         ST_POP:    state_in = shift_need ? ST_SHIFT : ST_FINISH;
         ST_SHIFT: begin
            if (sh_rd_ff == sh_stop) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath, memory accesses and result
   always_comb begin
      op_in          = op_ff;
      stat_in        = stat_ff;
      cnt_in         = cnt_ff;
      front_in       = front_ff;
      rev_in         = rev_ff;
      key_in         = key_ff;
      removed_in     = removed_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      rd_idx_in      = rd_idx_ff;
      rd_vld_in      = 1'b0;
      sh_rd_in       = sh_rd_ff;
      wr_phys_in     = wr_phys_ff;
      wr_vld_in      = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rd_en          = 1'b0;
      rd_addr        = front_ff;
      wr_en          = 1'b0;
      wr_addr        = front_ff;
      wr_data        = rd_data_ff;

      // write back an entry moved during a shift
      if (wr_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = slot_of(front_ff, wr_phys_ff);
         wr_data = rd_data_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in     = req_key;
               removed_in = '0;
               stat_in    = STAT_OK;
               op_in      = OP_NONE;
               idx_in     = '0;
               pos_in     = '0;
               case (act)
                  ACT_CLEAR: op_in = OP_CLEAR;
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     if (full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        op_in  = OP_INSERT;
                        pos_in = push_pos;
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     if (empty) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        // fetch the end entry for the removed key
                        op_in   = OP_REMOVE;
                        pos_in  = pop_pos;
                        rd_en   = 1'b1;
                        rd_addr = slot_of(front_ff, pop_pos);
                     end
                  end
                  ACT_SORTED_INSERT: begin
                     if (full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        op_in = OP_INSERT;
                     end
                  end
                  ACT_DELETE_KEY: begin
                     if (empty) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        op_in = OP_REMOVE;
                     end
                  end
                  ACT_REVERSE: begin
                     if (empty) begin
                        stat_in = STAT_EMPTY;
                     end else begin
                        op_in = OP_FLIP;
                     end
                  end
                  default: op_in = OP_NONE;
               endcase
            end
         end

         ST_SCAN: begin
            if (scan_hit || scan_end) begin
               if ((op_ff == OP_REMOVE) && !scan_hit) begin
                  stat_in = STAT_NOT_FOUND;
                  op_in   = OP_NONE;
               end else begin
                  pos_in = launch_pos;
                  if (op_ff == OP_REMOVE) begin
                     removed_in = key_ff;
                     sh_rd_in   = launch_pos + CNT_W'(1);
                  end else begin
                     sh_rd_in   = cnt_last;
                  end
               end
            end else if (idx_ff != cnt_ff) begin
               // issue the next read in list order
               rd_en     = 1'b1;
               rd_addr   = slot_of(front_ff, rev_ff ? (cnt_last - idx_ff) : idx_ff);
               rd_vld_in = 1'b1;
               rd_idx_in = idx_ff;
               idx_in    = idx_ff + CNT_W'(1);
            end
         end

         ST_POP: begin
            removed_in = rd_data_ff;
            sh_rd_in   = pos_ff + CNT_W'(1);
         end

         ST_SHIFT: begin
            // read one neighbor, write it one place over next cycle
            rd_en     = 1'b1;
            rd_addr   = slot_of(front_ff, sh_rd_ff);
            wr_vld_in = 1'b1;
            if (op_ff == OP_INSERT) begin
               wr_phys_in = sh_rd_ff + CNT_W'(1);
               sh_rd_in   = sh_rd_ff - CNT_W'(1);
            end else begin
               wr_phys_in = sh_rd_ff - CNT_W'(1);
               sh_rd_in   = sh_rd_ff + CNT_W'(1);
            end
         end

         ST_FINISH: begin
            case (op_ff)
               OP_INSERT: begin
                  wr_en   = 1'b1;
                  wr_data = key_ff;
                  if (pos_ff == '0) begin
                     front_in = front_dec;
                     wr_addr  = front_dec;
                  end else begin
                     wr_addr  = slot_of(front_ff, pos_ff);
                  end
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               OP_REMOVE: begin
                  if (pos_ff == '0) begin
                     front_in = front_inc;
                  end
                  cnt_in = cnt_last;
                  if (cnt_ff == CNT_W'(1)) begin
                     rev_in = 1'b0;
                  end
               end
               OP_CLEAR: begin
                  cnt_in   = '0;
                  front_in = '0;
                  rev_in   = 1'b0;
               end
               OP_FLIP: rev_in = !rev_ff;
               default: ;
            endcase
            rsp_valid_in   = 1'b1;
            rsp_status_in  = stat_ff;
            rsp_removed_in = removed_ff;
            rsp_count_in   = cnt_in;
         end

         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         front_ff     <= '0;
         rev_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         wr_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         front_ff     <= front_in;
         rev_ff       <= rev_in;
         rd_vld_ff    <= rd_vld_in;
         wr_vld_ff    <= wr_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      stat_ff        <= stat_in;
      key_ff         <= key_in;
      removed_ff     <= removed_in;
      pos_ff         <= pos_in;
      idx_ff         <= idx_in;
      rd_idx_ff      <= rd_idx_in;
      sh_rd_ff       <= sh_rd_in;
      wr_phys_ff     <= wr_phys_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   // memory read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= key_mem[rd_addr];
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_removed_key = rsp_removed_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

`default_nettype wire

### hdl/odle_checker.sv
// ----------------------------------------------------------------------------
// odle_checker
// Port-level checks of the ordered deque list engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module odle_checker
   import odle_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire logic                    rsp_valid,
   input wire logic [STATUS_W-1:0]     rsp_status,
   input wire logic signed [KEY_W-1:0] rsp_removed_key,
   input wire logic [CNT_W-1:0]        rsp_entry_count
);

   // an accepted command keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not raise busy");

   // a command ends exactly with its result transfer
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // a refused command removes nothing
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STAT_OK)) |-> (rsp_removed_key == '0))
      else $error("refused command reports a removed key");

   // full is only reported at capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_FULL)) |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("full status below capacity");

   // empty is only reported with nothing held
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_EMPTY)) |-> (rsp_entry_count == '0))
      else $error("empty status with entries held");

endmodule

bind ordered_deque_list_engine odle_checker #(
   .CAPACITY (CAPACITY)
) u_odle_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_removed_key (rsp_removed_key),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire
